FILE: sv/scancode_key_state_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// scancode key state tracker assertion macros
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_KEY_STATE_TRACKER_TOP_ASSERT_SVH
`define SCANCODE_KEY_STATE_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define SCKST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("sckst check failed");

// next-cycle implication, masked during reset
`define SCKST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("sckst check failed");

// next-cycle implication that also covers reset itself
`define SCKST_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> cons) \
    else $error("sckst reset check failed");

`endif

FILE: sv/sckst_pkg.sv
// ----------------------------------------------------------------------------
// sckst_pkg
// Types, codes and constants shared by the key state tracker files.
// ----------------------------------------------------------------------------
package sckst_pkg;

  localparam int KEY_COUNT_DEF = 96;

  localparam int FUNC_W = 2;
  localparam int BYTE_W = 8;
  localparam int KS_W   = 2;
  localparam int ENT_W  = 2;

  localparam int BREAK_BIT = 7;
  localparam logic [BYTE_W-1:0] CODE_MASK = 8'h7F;
  localparam logic [BYTE_W-1:0] PFX_NONE  = 8'h00;
  localparam logic [BYTE_W-1:0] PFX_EXT   = 8'hE0;
  localparam logic [BYTE_W-1:0] PFX_SKIP1 = 8'hE1;
  localparam logic [BYTE_W-1:0] PFX_SKIP2 = 8'hE2;

  // item selector on the input channel
  localparam logic [FUNC_W-1:0] FUNC_SCAN  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;
  // unused selector, changes nothing
  localparam logic [FUNC_W-1:0] FUNC_RSVD  = 2'd3;

  typedef enum logic [KS_W-1:0] {
    KS_UP       = 2'd0,
    KS_DOWN     = 2'd1,
    KS_PRESSED  = 2'd2,
    KS_RELEASED = 2'd3
  } key_state_t;

  // decoded work for the table stage
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_KEY   = 2'd1,
    OP_QUERY = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef struct packed {
    logic down;
    logic seen;
  } key_ent_t;

endpackage

FILE: sv/sckst_if.sv
// ----------------------------------------------------------------------------
// sckst channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sckst_in_if;
  logic                            valid;
  logic                            ready;
  logic [sckst_pkg::FUNC_W-1:0]    func;
  logic [sckst_pkg::BYTE_W-1:0]    raw_byte;
  logic                            ext_table;
  logic [sckst_pkg::BYTE_W-1:0]    key_index;

  modport source (output valid, output func, output raw_byte, output ext_table,
                  output key_index, input ready);
  modport sink (input valid, input func, input raw_byte, input ext_table,
                input key_index, output ready);
endinterface

interface sckst_out_if;
  logic                          valid;
  logic                          ready;
  logic [sckst_pkg::KS_W-1:0]    key_state;
  logic                          any_changed;

  modport source (output valid, output key_state, output any_changed, input ready);
  modport sink (input valid, input key_state, input any_changed, output ready);
endinterface

FILE: sv/sckst_ram.sv
// ----------------------------------------------------------------------------
// sckst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sckst_ram #(
  parameter int WIDTH = sckst_pkg::ENT_W,
  parameter int DEPTH = 2 * sckst_pkg::KEY_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/scancode_key_state_tracker_top.sv
// ----------------------------------------------------------------------------
// scancode_key_state_tracker_top
// Scancode set 1 key state tracker with key queries and a frame tick.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the output side is not stalled, and
// returns exactly one result per input transaction, in order. The key table
// RAM read is registered on the accepting edge together with the decoded
// transaction, and the result register loads from them once the output side
// can take a result. The normal and extended tables share one RAM of
// 2*KEY_COUNT two-bit entries (down, seen) with one valid flop per entry, so
// reset is immediate and no clearing pass is needed. A table write from the
// previous transaction is forwarded to the next one, which keeps back-to-back
// updates of one key exact.
module scancode_key_state_tracker_top #(
  parameter int KEY_COUNT = sckst_pkg::KEY_COUNT_DEF
) (
  input logic         clk,
  input logic         rst_n,
  sckst_in_if.sink    in_chan,
  sckst_out_if.source out_chan
);

  localparam int DEPTH = 2 * KEY_COUNT;
  localparam int AW    = $clog2(DEPTH);

  // decode stage
  logic                         in_acc;
  logic                         s1_adv;
  logic                         s1_fire;
  logic [sckst_pkg::BYTE_W-1:0] prefix_r;
  logic [sckst_pkg::BYTE_W-1:0] prefix_nxt;
  sckst_pkg::op_t               op_nxt;
  logic                         ext_nxt;
  logic [sckst_pkg::BYTE_W-1:0] idx_nxt;
  logic                         make_nxt;
  logic [AW-1:0]                addr_nxt;
  logic [sckst_pkg::BYTE_W-1:0] code8;

  logic                         s1_vld_r;
  sckst_pkg::op_t               s1_op_r;
  logic [AW-1:0]                s1_addr_r;
  logic                         s1_make_r;

  // table stage
  logic [DEPTH-1:0]             tbl_vld_r;
  logic                         fwd_vld_r;
  logic [AW-1:0]                fwd_addr_r;
  sckst_pkg::key_ent_t          fwd_data_r;
  logic [sckst_pkg::ENT_W-1:0]  ram_rdata;
  sckst_pkg::key_ent_t          cur;
  sckst_pkg::key_ent_t          ent_nxt;
  logic                         upd;
  logic                         tbl_we;
  logic                         any_r;
  logic                         any_nxt;
  sckst_pkg::key_state_t        ks;

  logic                         out_vld_r;
  sckst_pkg::key_state_t        out_ks_r;
  logic                         out_any_r;

  assign s1_adv        = !out_vld_r || out_chan.ready;
  assign s1_fire       = s1_vld_r && s1_adv;
  assign in_chan.ready = !s1_vld_r || s1_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign code8 = in_chan.raw_byte & sckst_pkg::CODE_MASK;

  // prefix tracking and table address, resolved when the transaction enters
  always_comb begin
    prefix_nxt = prefix_r;
    op_nxt     = sckst_pkg::OP_NONE;
    ext_nxt    = 1'b0;
    idx_nxt    = code8;
    make_nxt   = !in_chan.raw_byte[sckst_pkg::BREAK_BIT];
    unique case (in_chan.func)
      sckst_pkg::FUNC_SCAN: begin
        if (prefix_r == sckst_pkg::PFX_EXT) begin
          prefix_nxt = sckst_pkg::PFX_NONE;
          ext_nxt    = 1'b1;
          if (code8 < sckst_pkg::BYTE_W'(KEY_COUNT)) begin
            op_nxt = sckst_pkg::OP_KEY;
          end
        end else if (prefix_r == sckst_pkg::PFX_SKIP1 ||
                     prefix_r == sckst_pkg::PFX_SKIP2) begin
          prefix_nxt = sckst_pkg::PFX_NONE;
        end else if (in_chan.raw_byte >= sckst_pkg::PFX_EXT &&
                     in_chan.raw_byte <= sckst_pkg::PFX_SKIP2) begin
          prefix_nxt = in_chan.raw_byte;
        end else if (code8 < sckst_pkg::BYTE_W'(KEY_COUNT)) begin
          op_nxt = sckst_pkg::OP_KEY;
        end
      end
      sckst_pkg::FUNC_QUERY: begin
        ext_nxt = in_chan.ext_table;
        idx_nxt = in_chan.key_index;
        // out-of-range query answers up and touches nothing
        if (in_chan.key_index < sckst_pkg::BYTE_W'(KEY_COUNT)) begin
          op_nxt = sckst_pkg::OP_QUERY;
        end
      end
      sckst_pkg::FUNC_TICK: begin
        op_nxt = sckst_pkg::OP_TICK;
      end
      default: begin
        op_nxt = sckst_pkg::OP_NONE;
      end
    endcase
    addr_nxt = ext_nxt ? (AW'(KEY_COUNT) + AW'(idx_nxt)) : AW'(idx_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      prefix_r <= sckst_pkg::PFX_NONE;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
        prefix_r <= prefix_nxt;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= op_nxt;
      s1_addr_r <= addr_nxt;
      s1_make_r <= make_nxt;
    end
  end

  sckst_ram #(
    .WIDTH (sckst_pkg::ENT_W),
    .DEPTH (DEPTH)
  ) u_sckst_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (s1_addr_r),
    .wdata (ent_nxt),
    .re    (in_acc),
    .raddr (addr_nxt),
    .rdata (ram_rdata)
  );

  // RAM data misses a write made on the same edge as the read
  always_comb begin
    if (fwd_vld_r && fwd_addr_r == s1_addr_r) begin
      cur = fwd_data_r;
    end else if (tbl_vld_r[s1_addr_r]) begin
      cur = sckst_pkg::key_ent_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    ent_nxt = cur;
    any_nxt = any_r;
    ks      = sckst_pkg::KS_UP;
    upd     = 1'b0;
    unique case (s1_op_r)
      sckst_pkg::OP_KEY: begin
        if (cur.down != s1_make_r) begin
          ent_nxt.down = s1_make_r;
          ent_nxt.seen = 1'b0;
          any_nxt      = s1_make_r;
          upd          = 1'b1;
        end
      end
      sckst_pkg::OP_QUERY: begin
        if (cur.down) begin
          ks = cur.seen ? sckst_pkg::KS_DOWN : sckst_pkg::KS_PRESSED;
        end else begin
          ks = cur.seen ? sckst_pkg::KS_UP : sckst_pkg::KS_RELEASED;
        end
        ent_nxt.seen = 1'b1;
        upd          = 1'b1;
      end
      sckst_pkg::OP_TICK: begin
        any_nxt = 1'b0;
      end
      default: begin
        upd = 1'b0;
      end
    endcase
  end

  assign tbl_we = s1_fire && upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      fwd_vld_r <= 1'b0;
      any_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_r[s1_addr_r] <= 1'b1;
        fwd_vld_r            <= 1'b1;
      end
      if (s1_fire) begin
        any_r     <= any_nxt;
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= ent_nxt;
    end
    if (s1_fire) begin
      out_ks_r  <= ks;
      out_any_r <= any_nxt;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.key_state   = out_ks_r;
  assign out_chan.any_changed = out_any_r;

endmodule

FILE: sv/sckst_checker.sv
// ----------------------------------------------------------------------------
// sckst_checker
// Port-level checks for the key state tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "scancode_key_state_tracker_top_assert.svh"

module sckst_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sckst_pkg::KS_W-1:0] out_key_state,
  input logic                       out_any_changed
);

  // reset empties the result register
  `SCKST_ASSERT_RST(a_rst_empty, !rst_n, !out_valid)

  // a stalled result holds
  `SCKST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_key_state) && $stable(out_any_changed))

  // with the result register empty the input side never stalls
  `SCKST_ASSERT_NOW(a_no_bubble, !out_valid, in_ready)

  // every accepted transaction passes the decode register and reaches the output
  `SCKST_ASSERT_NEXT(a_latency, in_valid && in_ready, ##1 out_valid)

endmodule

bind scancode_key_state_tracker_top sckst_checker u_sckst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_key_state   (out_chan.key_state),
  .out_any_changed (out_chan.any_changed)
);

FILE: tb/scancode_key_state_tracker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode key state tracker checker
// Watches both channels, keeps its own copy of the key tables and prefix
// state, predicts one answer per input transaction and compares in order.
// ----------------------------------------------------------------------------
module scancode_key_state_tracker_checker #(
  parameter int KEY_COUNT = sckst_pkg::KEY_COUNT_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  sckst_in_if   in_mon,
  sckst_out_if  out_mon,
  output int    fail_count,
  output int    pending
);

  typedef struct packed {
    sckst_pkg::key_state_t state;
    logic                  any;
  } key_answer_t;

  // table 0 is the normal key table, table 1 the extended one
  logic                         key_down [2][KEY_COUNT];
  logic                         key_seen [2][KEY_COUNT];
  logic [sckst_pkg::BYTE_W-1:0] held_prefix;
  logic                         any_flag;
  key_answer_t                  key_answers_q[$];
  int                           fails = 0;

  assign fail_count = fails;

  task automatic report(input string what);
    $display("checker: %s", what);
    fails++;
  endtask

  function automatic void update_key(input int tbl, input int code, input logic make);
    if (code < KEY_COUNT && key_down[tbl][code] != make) begin
      key_down[tbl][code] = make;
      key_seen[tbl][code] = 1'b0;
      any_flag = make;
    end
  endfunction

  function automatic key_answer_t track_key_item(
    input logic [sckst_pkg::FUNC_W-1:0] func,
    input logic [sckst_pkg::BYTE_W-1:0] raw,
    input logic                         ext,
    input logic [sckst_pkg::BYTE_W-1:0] idx
  );
    key_answer_t ans;
    int          tbl;
    ans.state = sckst_pkg::KS_UP;
    tbl = ext ? 1 : 0;
    case (func)
      sckst_pkg::FUNC_SCAN: begin
        if (held_prefix == sckst_pkg::PFX_EXT) begin
          update_key(1, int'(raw & sckst_pkg::CODE_MASK), !raw[sckst_pkg::BREAK_BIT]);
          held_prefix = sckst_pkg::PFX_NONE;
        end else if (held_prefix == sckst_pkg::PFX_SKIP1 ||
                     held_prefix == sckst_pkg::PFX_SKIP2) begin
          // swallowed byte, whatever it looks like
          held_prefix = sckst_pkg::PFX_NONE;
        end else if (raw >= sckst_pkg::PFX_EXT && raw <= sckst_pkg::PFX_SKIP2) begin
          held_prefix = raw;
        end else begin
          update_key(0, int'(raw & sckst_pkg::CODE_MASK), !raw[sckst_pkg::BREAK_BIT]);
        end
      end
      sckst_pkg::FUNC_QUERY: begin
        if (idx < KEY_COUNT) begin
          if (key_down[tbl][idx]) begin
            ans.state = key_seen[tbl][idx] ? sckst_pkg::KS_DOWN : sckst_pkg::KS_PRESSED;
          end else begin
            ans.state = key_seen[tbl][idx] ? sckst_pkg::KS_UP : sckst_pkg::KS_RELEASED;
          end
          key_seen[tbl][idx] = 1'b1;
        end
      end
      sckst_pkg::FUNC_TICK: begin
        any_flag = 1'b0;
      end
      default: begin
      end
    endcase
    ans.any = any_flag;
    return ans;
  endfunction

  always @(posedge clk) begin
    key_answer_t want;
    if (!rst_n) begin
      for (int t = 0; t < 2; t++) begin
        for (int k = 0; k < KEY_COUNT; k++) begin
          key_down[t][k] = 1'b0;
          key_seen[t][k] = 1'b0;
        end
      end
      held_prefix = sckst_pkg::PFX_NONE;
      any_flag = 1'b0;
      key_answers_q.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (key_answers_q.size() == 0) begin
          report("result transaction with no input transaction waiting");
        end else begin
          want = key_answers_q.pop_front();
          if (out_mon.key_state !== want.state) begin
            report($sformatf("key_state got %0d want %0d",
                             out_mon.key_state, want.state));
          end
          if (out_mon.any_changed !== want.any) begin
            report($sformatf("any_changed got %0b want %0b",
                             out_mon.any_changed, want.any));
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        key_answers_q.push_back(track_key_item(in_mon.func, in_mon.raw_byte,
                                               in_mon.ext_table, in_mon.key_index));
      end
    end
    pending = key_answers_q.size();
  end

endmodule

FILE: tb/scancode_key_state_tracker_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode key state tracker testbench
// Drives directed and random scancode, query, tick and reserved transactions
// with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module scancode_key_state_tracker_top_test;

  localparam int ITEMS       = 600;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          pending;
  int unsigned cycles = 0;
  int          sent = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  sckst_in_if  in_chan ();
  sckst_out_if out_chan ();

  scancode_key_state_tracker_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  scancode_key_state_tracker_checker watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // now and then switch between idling at random and running flat out
  function automatic int next_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic [6:0] pick_code();
    // half the codes come from a few keys so queries find changed keys
    if ($urandom_range(0, 1) == 1) begin
      return 7'($urandom_range(0, 11));
    end
    return 7'($urandom_range(0, sckst_pkg::KEY_COUNT_DEF - 1));
  endfunction

  task automatic send_item(input logic [sckst_pkg::FUNC_W-1:0] func,
                           input logic [sckst_pkg::BYTE_W-1:0] raw,
                           input logic ext,
                           input logic [sckst_pkg::BYTE_W-1:0] idx);
    int gap;
    gap = next_gap(in_calm);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.func      <= func;
    in_chan.raw_byte  <= raw;
    in_chan.ext_table <= ext;
    in_chan.key_index <= idx;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sent++;
  endtask

  // unused fields carry random values
  task automatic send_scan(input logic [sckst_pkg::BYTE_W-1:0] raw);
    send_item(sckst_pkg::FUNC_SCAN, raw, 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic send_query(input logic ext, input logic [sckst_pkg::BYTE_W-1:0] idx);
    send_item(sckst_pkg::FUNC_QUERY, 8'($urandom_range(0, 255)), ext, idx);
  endtask

  task automatic send_tick();
    send_item(sckst_pkg::FUNC_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic send_rsvd();
    send_item(sckst_pkg::FUNC_RSVD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)));
  endtask

  // result side: a random stall, at times none, before each result transaction
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = next_gap(out_calm);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
    end
  end

  initial begin
    int r;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.func      <= sckst_pkg::FUNC_SCAN;
    in_chan.raw_byte  <= '0;
    in_chan.ext_table <= 1'b0;
    in_chan.key_index <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // untouched key answers released, then up
    send_query(1'b0, 8'd5);
    send_query(1'b0, 8'd5);
    send_scan(8'h05);
    send_scan(8'h05);
    send_query(1'b0, 8'd5);
    send_query(1'b0, 8'd5);
    send_scan(8'h85);
    send_query(1'b0, 8'd5);
    send_scan(8'h00);
    send_scan(8'h5F);
    // codes past the table change nothing
    send_scan(8'h60);
    send_scan(8'hFF);
    send_tick();
    send_scan(sckst_pkg::PFX_EXT);
    send_scan(8'h1D);
    send_query(1'b1, 8'h1D);
    send_query(1'b0, 8'h1D);
    // a prefix after the extended prefix is an extended code out of range
    send_scan(sckst_pkg::PFX_EXT);
    send_scan(sckst_pkg::PFX_EXT);
    // skip prefixes swallow the next byte, even another prefix
    send_scan(sckst_pkg::PFX_SKIP1);
    send_scan(sckst_pkg::PFX_EXT);
    send_scan(sckst_pkg::PFX_SKIP2);
    send_scan(8'h0A);
    send_query(1'b0, 8'd95);
    send_query(1'b0, 8'd96);
    send_query(1'b1, 8'd255);
    send_rsvd();

    while (sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_scan({1'($urandom_range(0, 1)), pick_code()});
      end else if (r < 45) begin
        send_scan(sckst_pkg::PFX_EXT);
        send_scan({1'($urandom_range(0, 1)), pick_code()});
      end else if (r < 50) begin
        send_scan($urandom_range(0, 1) ? sckst_pkg::PFX_SKIP1 : sckst_pkg::PFX_SKIP2);
        send_scan(8'($urandom_range(0, 255)));
      end else if (r < 55) begin
        send_scan(8'($urandom_range(0, 255)));
      end else if (r < 85) begin
        if ($urandom_range(0, 9) == 0) begin
          send_query(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end else begin
          send_query(1'($urandom_range(0, 1)), {1'b0, pick_code()});
        end
      end else if (r < 95) begin
        send_tick();
      end else begin
        send_rsvd();
      end
    end
    in_chan.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: scancode_key_state_tracker_top.f
+incdir+sv
sv/sckst_pkg.sv
sv/sckst_if.sv
sv/sckst_ram.sv
sv/scancode_key_state_tracker_top.sv
sv/sckst_checker.sv
tb/scancode_key_state_tracker_checker.sv
tb/scancode_key_state_tracker_top_test.sv
